[rtl/ier_pkg.sv]
// Shared widths, codes and defaults for the indexed element removal block.
package ier_pkg;

    localparam int IDX_W    = 17;  // delete index and array length
    localparam int DATA_W   = 32;  // element value
    localparam int POS_W    = 16;  // compacted position
    localparam int IGN_W    = 7;   // ignored entry count
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;

    localparam int DEF_MAX_DELETES = 64;
    localparam int DEF_MAX_LENGTH  = 65536;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR   = 2'd0,
        OP_PUSH    = 2'd1,
        OP_BEGIN   = 2'd2,
        OP_ELEMENT = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NO_ARRAY = 2'd3
    } status_t;

endpackage

[rtl/ier_list_mem.sv]
// Delete list storage: one write port, one read port with registered data.
module ier_list_mem #(
    parameter int DEPTH  = ier_pkg::DEF_MAX_DELETES,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [ADDR_W-1:0]        wr_addr,
    input  logic [ier_pkg::IDX_W-1:0] wr_data,
    input  logic                     rd_en,
    input  logic [ADDR_W-1:0]        rd_addr,
    output logic [ier_pkg::IDX_W-1:0] rd_data
);
    import ier_pkg::*;

    logic [IDX_W-1:0] mem [DEPTH];
    logic [IDX_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/indexed_element_removal_top.sv]
// Top level of the indexed element removal block: list control, element walk, result stage.
//
// The block holds an ascending list of element positions to delete and then
// marks each streamed element as kept or deleted, giving kept elements their
// place in the compacted array. Every request yields exactly one result.
// Clear, push, an element that is kept and a begin with an empty list give
// their result straight from the idle state. A new request is taken only while
// the output register is empty or in the cycle that the sink takes the result
// it holds, so a result left waiting holds off the request side. A begin with
// a non-empty list first reads the first list entry in S_BEGIN_RD. A deleted
// element walks the list in S_WALK, unless no entry is left, examining entries
// one at a time to find the next target on the single read port of the
// delete-list memory, whose read data is registered. The list memory is not
// cleared after reset: entries are only read below the fill count, so no
// clearing pass is needed.
module indexed_element_removal_top #(
    parameter int MAX_DELETES = ier_pkg::DEF_MAX_DELETES,
    parameter int MAX_LENGTH  = ier_pkg::DEF_MAX_LENGTH
) (
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [16:0] index_or_length, [48:17] element_data, [55:49] zero fill
    input  logic [55:0] s_axis_tdata,
    // [1:0] operation
    input  logic [ier_pkg::OP_W-1:0] s_axis_tuser,
    // result channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] element_out, [47:32] out_position, [54:48] ignored_count,
    // [71:55] kept_count
    output logic [71:0] m_axis_tdata,
    // [0] keep, [2:1] status
    output logic [2:0]  m_axis_tuser,
    // is_last
    output logic        m_axis_tlast
);
    import ier_pkg::*;

    localparam int CNT_W = $clog2(MAX_DELETES + 1);
    localparam int PTR_W = (MAX_DELETES > 1) ? $clog2(MAX_DELETES) : 1;
    localparam logic [CNT_W-1:0] LIST_FULL = CNT_W'(MAX_DELETES);
    localparam logic [IDX_W-1:0] LEN_CAP =
        (MAX_LENGTH >= (1 << IDX_W) - 1) ? {IDX_W{1'b1}} : IDX_W'(MAX_LENGTH);
    localparam logic [IGN_W-1:0] IGN_MAX = {IGN_W{1'b1}};

    typedef enum logic [1:0] {
        S_IDLE,
        S_BEGIN_RD,
        S_WALK
    } state_t;

    // control state
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] list_count_reg, list_count_next;
    logic [CNT_W-1:0] pointer_reg, pointer_next;
    logic [IDX_W-1:0] target_reg, target_next;
    logic             tgt_valid_reg, tgt_valid_next;
    logic [IDX_W-1:0] elem_reg, elem_next;
    logic [IDX_W-1:0] length_reg, length_next;
    logic [IDX_W-1:0] kept_reg, kept_next;
    logic [IGN_W-1:0] ign_reg, ign_next;
    logic             active_reg, active_next;

    // result register
    logic             out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_eout_reg, out_eout_next;
    logic             out_keep_reg, out_keep_next;
    logic [POS_W-1:0] out_pos_reg, out_pos_next;
    logic             out_last_reg, out_last_next;
    status_t          out_status_reg, out_status_next;
    logic [IGN_W-1:0] out_ign_reg, out_ign_next;
    logic [IDX_W-1:0] out_kept_reg, out_kept_next;

    // list memory ports
    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    logic             rd_en;
    logic [PTR_W-1:0] rd_addr;
    logic [IDX_W-1:0] rd_data;

    // request fields
    op_t              op_in;
    logic [IDX_W-1:0] val_in;
    logic [DATA_W-1:0] data_in;
    logic [IDX_W-1:0] len_sat;
    logic             in_accept;

    // helpers
    logic [CNT_W:0]   ptr_inc;
    logic [IDX_W:0]   elem_inc;
    logic             walk_end;
    logic             done;

    assign op_in   = op_t'(s_axis_tuser);
    assign val_in  = s_axis_tdata[IDX_W-1:0];
    assign data_in = s_axis_tdata[IDX_W+DATA_W-1:IDX_W];
    assign len_sat = (val_in > LEN_CAP) ? LEN_CAP : val_in;

    // Take a request only between walks and when the result slot frees up.
    assign s_axis_tready = (state_reg == S_IDLE) && (!out_valid_reg || m_axis_tready);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign ptr_inc  = {1'b0, pointer_reg} + 1'b1;
    assign elem_inc = {1'b0, elem_reg} + 1'b1;
    // No entry left after the current one: the target runs out.
    assign walk_end = ptr_inc >= {1'b0, list_count_reg};

    assign wr_addr = list_count_reg[PTR_W-1:0];

    ier_list_mem #(
        .DEPTH (MAX_DELETES)
    ) u_list_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (val_in),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next      = state_reg;
        list_count_next = list_count_reg;
        pointer_next    = pointer_reg;
        target_next     = target_reg;
        tgt_valid_next  = tgt_valid_reg;
        elem_next       = elem_reg;
        length_next     = length_reg;
        kept_next       = kept_reg;
        ign_next        = ign_reg;
        active_next     = active_reg;

        out_valid_next  = out_valid_reg;
        out_eout_next   = out_eout_reg;
        out_keep_next   = out_keep_reg;
        out_pos_next    = out_pos_reg;
        out_last_next   = out_last_reg;
        out_status_next = out_status_reg;
        out_ign_next    = out_ign_reg;
        out_kept_next   = out_kept_reg;

        wr_en   = 1'b0;
        rd_en   = 1'b0;
        rd_addr = ptr_inc[PTR_W-1:0];
        done    = 1'b0;

        // Drop the result once the sink takes it.
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    out_eout_next   = '0;
                    out_keep_next   = 1'b0;
                    out_pos_next    = '0;
                    out_last_next   = 1'b0;
                    out_status_next = ST_OK;
                    unique case (op_in)
                        OP_CLEAR:
                        begin
                            list_count_next = '0;
                            pointer_next    = '0;
                            tgt_valid_next  = 1'b0;
                            ign_next        = '0;
                            active_next     = 1'b0;
                            done            = 1'b1;
                        end
                        OP_PUSH:
                        begin
                            if (list_count_reg == LIST_FULL)
                            begin
                                out_status_next = ST_FULL;
                            end
                            else
                            begin
                                wr_en           = 1'b1;
                                list_count_next = list_count_reg + 1'b1;
                            end
                            done = 1'b1;
                        end
                        OP_BEGIN:
                        begin
                            length_next    = len_sat;
                            elem_next      = '0;
                            kept_next      = '0;
                            ign_next       = '0;
                            pointer_next   = '0;
                            tgt_valid_next = 1'b0;
                            active_next    = (len_sat != '0);
                            if (list_count_reg != '0)
                            begin
                                // fetch the first entry to set the target
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                state_next = S_BEGIN_RD;
                            end
                            else
                            begin
                                done = 1'b1;
                            end
                        end
                        OP_ELEMENT:
                        begin
                            out_eout_next = data_in;
                            if (!active_reg)
                            begin
                                out_status_next = ST_NO_ARRAY;
                                done            = 1'b1;
                            end
                            else
                            begin
                                if (elem_inc >= {1'b0, length_reg})
                                begin
                                    out_last_next = 1'b1;
                                    active_next   = 1'b0;
                                end
                                elem_next = elem_inc[IDX_W-1:0];
                                if (tgt_valid_reg && (elem_reg == target_reg))
                                begin
                                    // deleted: move on to the next greater entry
                                    if (walk_end)
                                    begin
                                        tgt_valid_next = 1'b0;
                                        done           = 1'b1;
                                    end
                                    else
                                    begin
                                        pointer_next = ptr_inc[CNT_W-1:0];
                                        rd_en        = 1'b1;
                                        rd_addr      = ptr_inc[PTR_W-1:0];
                                        state_next   = S_WALK;
                                    end
                                end
                                else
                                begin
                                    out_keep_next = 1'b1;
                                    out_pos_next  = kept_reg[POS_W-1:0];
                                    kept_next     = kept_reg + 1'b1;
                                    done          = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            done = 1'b1;
                        end
                    endcase
                end
            end
            S_BEGIN_RD:
            begin
                if (rd_data >= length_reg)
                begin
                    out_status_next = ST_RANGE;
                end
                else
                begin
                    target_next    = rd_data;
                    tgt_valid_next = 1'b1;
                end
                done       = 1'b1;
                state_next = S_IDLE;
            end
            S_WALK:
            begin
                if (rd_data > target_reg)
                begin
                    // an entry past the array end still becomes the target
                    if ((rd_data >= length_reg) && (ign_reg != IGN_MAX))
                    begin
                        ign_next = ign_reg + 1'b1;
                    end
                    target_next = rd_data;
                    done        = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    // repeated or descending entry: skip and count
                    if (ign_reg != IGN_MAX)
                    begin
                        ign_next = ign_reg + 1'b1;
                    end
                    if (walk_end)
                    begin
                        tgt_valid_next = 1'b0;
                        done           = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        pointer_next = ptr_inc[CNT_W-1:0];
                        rd_en        = 1'b1;
                        rd_addr      = ptr_inc[PTR_W-1:0];
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Publish the result with the totals as they stand after this request.
        if (done)
        begin
            out_valid_next = 1'b1;
            out_ign_next   = ign_next;
            out_kept_next  = kept_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            list_count_reg <= '0;
            pointer_reg    <= '0;
            target_reg     <= '0;
            tgt_valid_reg  <= 1'b0;
            elem_reg       <= '0;
            length_reg     <= '0;
            kept_reg       <= '0;
            ign_reg        <= '0;
            active_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_eout_reg   <= '0;
            out_keep_reg   <= 1'b0;
            out_pos_reg    <= '0;
            out_last_reg   <= 1'b0;
            out_status_reg <= ST_OK;
            out_ign_reg    <= '0;
            out_kept_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            list_count_reg <= list_count_next;
            pointer_reg    <= pointer_next;
            target_reg     <= target_next;
            tgt_valid_reg  <= tgt_valid_next;
            elem_reg       <= elem_next;
            length_reg     <= length_next;
            kept_reg       <= kept_next;
            ign_reg        <= ign_next;
            active_reg     <= active_next;
            out_valid_reg  <= out_valid_next;
            out_eout_reg   <= out_eout_next;
            out_keep_reg   <= out_keep_next;
            out_pos_reg    <= out_pos_next;
            out_last_reg   <= out_last_next;
            out_status_reg <= out_status_next;
            out_ign_reg    <= out_ign_next;
            out_kept_reg   <= out_kept_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_kept_reg, out_ign_reg, out_pos_reg, out_eout_reg};
    assign m_axis_tuser  = {out_status_reg, out_keep_reg};
    assign m_axis_tlast  = out_last_reg;

    // The result slot is empty whenever a list read is in flight.
    a_slot_free_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !out_valid_reg)
        else $error("result pending while list read in flight");

    // A walk only runs from a live target.
    a_walk_has_target: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> tgt_valid_reg)
        else $error("list walk without a target");

    // The fill count never passes the list depth.
    a_list_bound: assert property (@(posedge clk) disable iff (!rst_n)
        list_count_reg <= LIST_FULL)
        else $error("delete list overfilled");

    // A kept element always carries an ok status.
    a_keep_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_keep_reg) |-> (out_status_reg == ST_OK))
        else $error("kept element with error status");

endmodule

[sim/tb_top.sv]
// Self-checking testbench for the indexed element removal block.
`timescale 1ns / 1ps

module tb_top;
    import ier_pkg::*;

    // Block geometry as built with its default parameters
    localparam int          MAX_DEL  = DEF_MAX_DELETES;
    localparam int unsigned MAX_LEN  = DEF_MAX_LENGTH;
    localparam int unsigned NO_TGT   = 32'hFFFF_FFFF;
    localparam int unsigned IDX_TOP  = (1 << IDX_W) - 1;

    // Stimulus size and timing knobs
    localparam int RANDOM_ITEMS = 1850;
    localparam int HOLD_AT      = 600;   // accepted requests before the long receiver hold-off
    localparam int HOLD_CYCLES  = 400;
    // A deleted element may walk the whole list; add margin.
    localparam int DRAIN_CYCLES = 100;
    // Longest correct stretch with no handshake on either side: the hold-off, plus a
    // full list walk, plus the longest random gap. Allow several times that.
    localparam int IDLE_LIMIT   = 2000;

    typedef struct {
        op_t        op;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] data;
    } req_t;

    typedef struct {
        logic [DATA_W-1:0] elem;
        logic              keep;
        logic [POS_W-1:0]  pos;
        logic              last;
        status_t           status;
        logic [IGN_W-1:0]  ign;
        logic [IDX_W-1:0]  kept;
    } mark_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Drive every input to a known value from time zero
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata  = '0;
    logic [OP_W-1:0] s_tuser = OP_CLEAR;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    indexed_element_removal_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser),
        .m_axis_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    req_t  pending_reqs[$];
    mark_t expected_marks[$];

    // Shadow copy of the block's state, advanced once per accepted request
    int unsigned del_list [MAX_DEL];
    int unsigned list_cnt   = 0;
    int unsigned list_ptr   = 0;
    int unsigned cur_target = NO_TGT;
    int unsigned elem_cnt   = 0;
    int unsigned arr_len    = 0;
    int unsigned kept_tot   = 0;
    int unsigned ign_tot    = 0;
    bit          arr_active = 1'b0;

    // Counters and handshake bookkeeping
    int  n_err       = 0;
    int  n_acc       = 0;
    int  n_checked   = 0;
    int  n_directed  = 0;
    int  n_kept      = 0;
    int  n_deleted   = 0;
    int  n_last      = 0;
    int  n_range     = 0;
    int  n_full      = 0;
    int  n_no_array  = 0;
    int  idle_cycles = 0;
    int  cyc         = 0;
    bit  req_taken   = 1'b0;
    int  send_gap    = 0;
    int  stall_left  = 0;
    int  hold_left   = 0;
    bit  hold_done   = 1'b0;

    // ------------------------------------------------------------------
    // Reference behavior
    // ------------------------------------------------------------------

    function automatic void bump_ignored();
        if (ign_tot < 127)
            ign_tot++;
    endfunction

    // Move the target to the next strictly greater list entry; entries that are
    // not greater are skipped and counted, and one at or past the end is counted.
    function automatic void walk_to_next_target();
        int unsigned nxt;
        bit          done;
        done = 1'b0;
        while (!done) begin
            if (list_ptr + 1 >= list_cnt || list_ptr + 1 >= MAX_DEL) begin
                cur_target = NO_TGT;
                done = 1'b1;
            end else begin
                list_ptr++;
                nxt = del_list[list_ptr];
                if (nxt > cur_target) begin
                    if (nxt >= arr_len)
                        bump_ignored();
                    cur_target = nxt;
                    done = 1'b1;
                end else begin
                    bump_ignored();
                end
            end
        end
    endfunction

    // Compute the result of one request and advance the shadow state
    function automatic mark_t predict_mark(req_t rq);
        mark_t m;
        m.elem   = '0;
        m.keep   = 1'b0;
        m.pos    = '0;
        m.last   = 1'b0;
        m.status = ST_OK;
        case (rq.op)
            OP_CLEAR: begin
                list_cnt   = 0;
                list_ptr   = 0;
                cur_target = NO_TGT;
                ign_tot    = 0;
                arr_active = 1'b0;
            end
            OP_PUSH: begin
                if (list_cnt >= MAX_DEL) begin
                    m.status = ST_FULL;
                end else begin
                    del_list[list_cnt] = rq.idx;   // all 17 bits are kept
                    list_cnt++;
                end
            end
            OP_BEGIN: begin
                arr_len    = (rq.idx > MAX_LEN) ? MAX_LEN : rq.idx;
                elem_cnt   = 0;
                kept_tot   = 0;
                ign_tot    = 0;
                list_ptr   = 0;
                cur_target = NO_TGT;
                if (list_cnt > 0) begin
                    if (del_list[0] >= arr_len)
                        m.status = ST_RANGE;
                    else
                        cur_target = del_list[0];
                end
                arr_active = (arr_len > 0);
            end
            default: begin
                m.elem = rq.data;
                if (!arr_active) begin
                    m.status = ST_NO_ARRAY;
                end else begin
                    if (elem_cnt == cur_target) begin
                        walk_to_next_target();
                    end else begin
                        m.keep = 1'b1;
                        m.pos  = kept_tot[POS_W-1:0];
                        kept_tot++;
                    end
                    if (elem_cnt + 1 >= arr_len) begin
                        m.last     = 1'b1;
                        arr_active = 1'b0;
                    end
                    elem_cnt++;
                end
            end
        endcase
        m.ign  = ign_tot[IGN_W-1:0];
        m.kept = kept_tot[IDX_W-1:0];
        return m;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------

    task automatic add_req(op_t op, int unsigned idx, logic [DATA_W-1:0] data);
        req_t rq;
        rq.op   = op;
        rq.idx  = idx[IDX_W-1:0];
        rq.data = data;
        pending_reqs.push_back(rq);
    endtask

    // Mostly short gaps, now and then a long one
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // One run: usually clear, a mostly ascending delete list, begin, the elements.
    // Some runs are noise or broken (cut short, overrun, push mid-array, no clear).
    task automatic gen_array_run();
        int unsigned r, len, eff, nd, n_el, ent, val, maxstep, ins_at, i;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            repeat ($urandom_range(1, 6))
                add_req(op_t'($urandom_range(0, 3)), $urandom_range(0, IDX_TOP), $urandom());
        end else begin
            if ($urandom_range(0, 9) != 0)
                add_req(OP_CLEAR, $urandom_range(0, IDX_TOP), $urandom());

            r = $urandom_range(0, 99);
            if (r < 70)
                len = $urandom_range(1, 16);
            else if (r < 90)
                len = $urandom_range(17, 80);
            else if (r < 96)
                len = $urandom_range(81, 300);
            else if (r < 98)
                len = 0;
            else
                len = $urandom_range(MAX_LEN, IDX_TOP);   // saturating length
            eff = (len > 300) ? 8 : len;

            r = $urandom_range(0, 99);
            if (r < 80)
                nd = $urandom_range(0, 6);
            else if (r < 95)
                nd = $urandom_range(7, 20);
            else
                nd = $urandom_range(MAX_DEL - 4, MAX_DEL + 6);   // fill and overflow the list

            maxstep = (eff * 2) / (nd + 1) + 1;
            ent = 0;
            for (i = 0; i < nd; i++) begin
                r = $urandom_range(0, 99);
                if (i == 0) begin
                    if (r < 5)
                        ent = $urandom_range(len, IDX_TOP);   // first entry outside
                    else
                        ent = $urandom_range(0, maxstep - 1);
                    val = ent;
                end else if (r < 6) begin
                    val = (ent > 0) ? $urandom_range(0, ent - 1) : 0;   // descending
                end else if (r < 12) begin
                    val = ent;                                          // repeated
                end else begin
                    ent = ent + $urandom_range(1, maxstep);
                    if (ent > IDX_TOP)
                        ent = IDX_TOP;
                    val = ent;
                end
                add_req(OP_PUSH, val, $urandom());
            end

            add_req(OP_BEGIN, len, $urandom());

            n_el = (len > 300) ? $urandom_range(1, 12) : len;
            r = $urandom_range(0, 99);
            if (r < 6)
                n_el = $urandom_range(0, n_el);          // stop early
            else if (r < 12)
                n_el = n_el + $urandom_range(1, 3);      // run past the end
            ins_at = ($urandom_range(0, 19) == 0) ? $urandom_range(0, n_el) : n_el + 10;
            for (i = 0; i < n_el; i++) begin
                if (i == ins_at)
                    add_req(OP_PUSH, $urandom_range(0, eff + 2), $urandom());
                add_req(OP_ELEMENT, $urandom_range(0, IDX_TOP), $urandom());
            end
        end
    endtask

    task automatic gen_directed();
        // Element before any array, then a zero-length begin that starts nothing
        add_req(OP_ELEMENT, 0, 32'hFFFF_FFFF);
        add_req(OP_BEGIN, 0, 32'h0);
        add_req(OP_ELEMENT, IDX_TOP, 32'h0);
        // Index 65536 stays out of range against a saturated length
        add_req(OP_CLEAR, 0, 32'h0);
        add_req(OP_PUSH, MAX_LEN, 32'hFFFF_FFFF);
        add_req(OP_BEGIN, IDX_TOP, 32'h0);
        add_req(OP_ELEMENT, 0, 32'hFFFF_FFFF);
        add_req(OP_ELEMENT, 0, 32'h0000_0000);
        // Repeated, descending and beyond-end entries, plus a push mid-array
        add_req(OP_CLEAR, 0, 32'h0);
        add_req(OP_PUSH, 0, 32'h0);
        add_req(OP_PUSH, 0, 32'h0);
        add_req(OP_PUSH, 2, 32'h0);
        add_req(OP_PUSH, 1, 32'h0);
        add_req(OP_PUSH, 9, 32'h0);
        add_req(OP_BEGIN, 4, 32'h0);
        add_req(OP_ELEMENT, 0, 32'hA5A5_A5A5);
        add_req(OP_ELEMENT, 0, 32'h5A5A_5A5A);
        add_req(OP_PUSH, 3, 32'h0);
        add_req(OP_ELEMENT, 0, 32'h1234_5678);
        add_req(OP_ELEMENT, 0, 32'h8765_4321);
        add_req(OP_ELEMENT, 0, 32'hDEAD_BEEF);   // after the last element
        // Empty list: nothing is deleted
        add_req(OP_CLEAR, 0, 32'h0);
        add_req(OP_BEGIN, 1, 32'h0);
        add_req(OP_ELEMENT, 0, 32'hCAFE_F00D);
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what, longint got, longint want);
        n_err++;
        $display("[%0t] mismatch on result %0d: %s got 0x%0h, expected 0x%0h",
                 $realtime, n_checked, what, got, want);
    endtask

    task automatic check_mark(mark_t want);
        mark_t got;
        got.elem   = m_tdata[31:0];
        got.pos    = m_tdata[47:32];
        got.ign    = m_tdata[54:48];
        got.kept   = m_tdata[71:55];
        got.keep   = m_tuser[0];
        got.status = status_t'(m_tuser[2:1]);
        got.last   = m_tlast;
        if (got.elem !== want.elem)     report_mismatch("element_out", got.elem, want.elem);
        if (got.keep !== want.keep)     report_mismatch("keep", got.keep, want.keep);
        if (got.pos !== want.pos)       report_mismatch("out_position", got.pos, want.pos);
        if (got.last !== want.last)     report_mismatch("is_last", got.last, want.last);
        if (got.status !== want.status) report_mismatch("status", got.status, want.status);
        if (got.ign !== want.ign)       report_mismatch("ignored_count", got.ign, want.ign);
        if (got.kept !== want.kept)     report_mismatch("kept_count", got.kept, want.kept);
    endtask

    // ------------------------------------------------------------------
    // Rising edge: take accepted requests into the predictor, check results,
    // and run the watchdog. Outputs are sampled here, before the block updates.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        bit   in_fire;
        bit   out_fire;
        mark_t m;
        in_fire  = rst_n && s_tvalid && s_tready;
        out_fire = rst_n && m_tvalid && m_tready;
        req_taken = in_fire;
        cyc++;

        if (in_fire) begin
            m = predict_mark(pending_reqs[0]);
            expected_marks.push_back(m);
            void'(pending_reqs.pop_front());
            n_acc++;
        end

        if (out_fire) begin
            if (expected_marks.size() == 0) begin
                n_err++;
                $display("[%0t] result with no request outstanding: tdata 0x%0h tuser 0x%0h",
                         $realtime, m_tdata, m_tuser);
            end else begin
                m = expected_marks.pop_front();
                check_mark(m);
                n_checked++;
                if (m.keep)
                    n_kept++;
                else if (m.status == ST_OK && m.elem !== '0)
                    n_deleted++;
                if (m.last)
                    n_last++;
                case (m.status)
                    ST_RANGE:    n_range++;
                    ST_FULL:     n_full++;
                    ST_NO_ARRAY: n_no_array++;
                    default:     ;
                endcase
            end
        end

        // Count cycles with no handshake at all; stop a hung run
        if (in_fire || out_fire)
            idle_cycles = 0;
        else if (rst_n)
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[%0t] watchdog: no handshake for %0d cycles, %0d requests pending, %0d results owed",
                     $realtime, idle_cycles, pending_reqs.size(), expected_marks.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Falling edge: request driver. Hold a presented request until it is taken,
    // then insert a random gap. Every fourth stretch runs gap-free.
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!(s_tvalid && !req_taken)) begin
            if (req_taken)
                send_gap = ((cyc / 400) % 4 == 0) ? 0 : draw_gap();
            if (send_gap > 0 || pending_reqs.size() == 0) begin
                if (send_gap > 0)
                    send_gap--;
                s_tvalid <= 1'b0;
            end else begin
                s_tvalid <= 1'b1;
                s_tdata  <= {7'd0, pending_reqs[0].data, pending_reqs[0].idx};
                s_tuser  <= pending_reqs[0].op;
            end
        end
    end

    // ------------------------------------------------------------------
    // Falling edge: result receiver. Stall at random, and once drop ready for a
    // long stretch so the block backs up and stalls its request side.
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (!hold_done && n_acc >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            stall_left = ((cyc / 400) % 4 == 1) ? 0 : draw_gap();
        end
    end

    // ------------------------------------------------------------------
    // Build the stimulus, release reset, drain and report
    // ------------------------------------------------------------------
    initial begin
        gen_directed();
        n_directed = pending_reqs.size();
        while (pending_reqs.size() < n_directed + RANDOM_ITEMS)
            gen_array_run();

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || expected_marks.size() != 0)
            @(posedge clk);
        // Let any stray result show up before closing
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_marks.size() != 0) begin
            n_err++;
            $display("%0d expected results never arrived", expected_marks.size());
        end

        $display("Ran %0d requests (%0d directed), checked %0d results: %0d kept, %0d deleted, %0d array ends",
                 n_acc, n_directed, n_checked, n_kept, n_deleted, n_last);
        $display("Status cases seen: %0d first-index-out-of-range, %0d list-full, %0d no-array; %0d mismatches",
                 n_range, n_full, n_no_array, n_err);
        if (n_err == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[filelist.f]
rtl/ier_pkg.sv
rtl/ier_list_mem.sv
rtl/indexed_element_removal_top.sv
sim/tb_top.sv
